>>> rtl/core/sfr_pkg.sv
`default_nettype none
// ============================================================================
// sfr_pkg: shared definitions for the stuffed frame receiver
// Line byte codes, header control codes, frame status codes, register map.
// ============================================================================
package sfr_pkg;

    // Line framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // Information frame control bytes
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] CTRL_SEQ1 = 8'h40;

    // Reset value of the address register
    localparam logic [7:0] ADDR_RESET = 8'h03;

    // Register map: register index taken from the word address
    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  REG_ADDRESS  = 1'b0;

    // Result stream data width (fields padded to whole bytes)
    localparam int M_TDATA_W = 16;

    // Frame status reported at the closing flag
    typedef enum logic [1:0] {
        STAT_GOOD_NEW = 2'd0,
        STAT_GOOD_DUP = 2'd1,
        STAT_BAD_EXP  = 2'd2,
        STAT_BAD_DUP  = 2'd3
    } frame_status_t;

    // One result item
    typedef struct packed {
        logic          reply_seq;
        logic          reply_is_reject;
        frame_status_t frame_status;
        logic          frame_done;
        logic [7:0]    data_byte;
        logic          data_valid;
    } result_t;

endpackage : sfr_pkg
`default_nettype wire

>>> rtl/core/stuffed_frame_receiver.sv
`default_nettype none
// ============================================================================
// stuffed_frame_receiver: byte-stuffed information frame receiver
// Hunts flag, address, control and header check, destuffs payload, holds
// back one payload byte so the check byte is never sent, and reports frame
// status with an RR or REJ stop-and-wait reply at the closing flag.
// ============================================================================
//
//  channel   direction  ports                         contents
//  --------  ---------  ----------------------------  ---------------------------
//  s_        in         s_tvalid s_tready s_tdata     rx_byte
//  m_        out        m_tvalid m_tready m_tdata     data_byte, status, reply
//                       m_tlast m_tuser               frame_done, data_valid
//  apb       in/out     psel penable pwrite paddr ... address_byte at 0x0
//
//  Every accepted line byte yields exactly one result transfer, from the result register.
//  One byte per cycle is sustained while m_tready is high: the parser state updates
//  on each accepted byte and the result register is reloaded in the cycle it is taken.
//  s_tready drops only while a result waits and m_tready is low.
//  Reset (aresetn low, synchronous) returns the parser to flag hunting, clears
//  both sequence bits and sets address_byte to 0x03.
//
module stuffed_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                                 // [10] reply_is_reject, [11] reply_seq,
                                                 // [15:12] zero
    output logic                      m_tlast,   // frame_done
    output logic                      m_tuser,   // [0] data_valid
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_FLAG = 3'd1,
        ST_ADDR = 3'd2,
        ST_CTRL = 3'd3,
        ST_DATA = 3'd4,
        ST_ESC  = 3'd5
    } parse_state_t;

    parse_state_t state_reg, state_next;
    logic         frame_seq_reg, frame_seq_next;
    logic         expected_seq_reg, expected_seq_next;
    logic [7:0]   held_byte_reg, held_byte_next;
    logic         held_valid_reg, held_valid_next;
    logic [7:0]   running_xor_reg, running_xor_next;
    logic [7:0]   address_reg;

    result_t      res_next, res_reg;
    logic         m_valid_reg;

    logic         s_xfer;
    logic         cfg_write;
    logic         take_en;
    logic [7:0]   take_byte;
    logic         good;
    logic         expected;
    logic [7:0]   hdr_check;

    // Handshakes
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration readback
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_ADDRESS) begin
            prdata = {24'd0, address_reg};
        end
    end

    assign hdr_check = address_reg ^ (frame_seq_reg ? CTRL_SEQ1 : CTRL_SEQ0);
    assign good      = held_valid_reg && (running_xor_reg == 8'd0);
    assign expected  = (frame_seq_reg == expected_seq_reg);

    // Parse one line byte
    always_comb begin
        state_next        = state_reg;
        frame_seq_next    = frame_seq_reg;
        expected_seq_next = expected_seq_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        running_xor_next  = running_xor_reg;
        res_next          = '0;
        take_en           = 1'b0;
        take_byte         = s_tdata;

        unique case (state_reg)
            ST_FLAG: begin
                if (s_tdata == address_reg) begin
                    state_next = ST_ADDR;
                end else if (s_tdata != FLAG_BYTE) begin
                    state_next = ST_HUNT;
                end
            end
            ST_ADDR: begin
                priority if (s_tdata == CTRL_SEQ0) begin
                    frame_seq_next = 1'b0;
                    state_next     = ST_CTRL;
                end else if (s_tdata == CTRL_SEQ1) begin
                    frame_seq_next = 1'b1;
                    state_next     = ST_CTRL;
                end else if (s_tdata == FLAG_BYTE) begin
                    state_next = ST_FLAG;
                end else begin
                    state_next = ST_HUNT;
                end
            end
            ST_CTRL: begin
                priority if (s_tdata == hdr_check) begin
                    state_next       = ST_DATA;
                    held_valid_next  = 1'b0;
                    held_byte_next   = 8'd0;
                    running_xor_next = 8'd0;
                end else if (s_tdata == FLAG_BYTE) begin
                    state_next = ST_FLAG;
                end else begin
                    state_next = ST_HUNT;
                end
            end
            ST_DATA: begin
                priority if (s_tdata == ESC_BYTE) begin
                    state_next = ST_ESC;
                end else if (s_tdata == FLAG_BYTE) begin
                    // judge the frame and build the reply
                    res_next.frame_done = 1'b1;
                    priority if (good && expected) begin
                        res_next.frame_status = STAT_GOOD_NEW;
                        expected_seq_next     = !expected_seq_reg;
                    end else if (good) begin
                        res_next.frame_status = STAT_GOOD_DUP;
                    end else if (expected) begin
                        res_next.frame_status    = STAT_BAD_EXP;
                        res_next.reply_is_reject = 1'b1;
                    end else begin
                        res_next.frame_status = STAT_BAD_DUP;
                    end
                    res_next.reply_seq = expected_seq_next;
                    held_valid_next    = 1'b0;
                    held_byte_next     = 8'd0;
                    running_xor_next   = 8'd0;
                    state_next         = ST_HUNT;
                end else begin
                    take_en = 1'b1;
                end
            end
            ST_ESC: begin
                // drop a bad escape pair
                if (s_tdata == ESC_FLAG) begin
                    take_en   = 1'b1;
                    take_byte = FLAG_BYTE;
                end else if (s_tdata == ESC_ESC) begin
                    take_en   = 1'b1;
                    take_byte = ESC_BYTE;
                end
                state_next = ST_DATA;
            end
            default: begin
                state_next = (s_tdata == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
            end
        endcase

        // Emit the held byte and hold the new one
        if (take_en) begin
            if (held_valid_reg) begin
                res_next.data_valid = 1'b1;
                res_next.data_byte  = held_byte_reg;
            end
            held_byte_next   = take_byte;
            held_valid_next  = 1'b1;
            running_xor_next = running_xor_reg ^ take_byte;
        end
    end

    // State, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_HUNT;
            frame_seq_reg    <= 1'b0;
            expected_seq_reg <= 1'b0;
            held_byte_reg    <= 8'd0;
            held_valid_reg   <= 1'b0;
            running_xor_reg  <= 8'd0;
            address_reg      <= ADDR_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write && paddr[PADDR_W-1] == REG_ADDRESS) begin
                address_reg <= pwdata[7:0];
            end
            if (s_xfer) begin
                state_reg        <= state_next;
                frame_seq_reg    <= frame_seq_next;
                expected_seq_reg <= expected_seq_next;
                held_byte_reg    <= held_byte_next;
                held_valid_reg   <= held_valid_next;
                running_xor_reg  <= running_xor_next;
                m_valid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    // Drive the result stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, res_reg.reply_seq, res_reg.reply_is_reject,
                       res_reg.frame_status, res_reg.data_byte};
    assign m_tlast  = res_reg.frame_done;
    assign m_tuser  = res_reg.data_valid;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while a result is stalled");

    a_payload_not_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser))
        else $error("payload byte and frame close in one transfer");

    a_reject_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |->
            (res_reg.reply_is_reject == (res_reg.frame_status == STAT_BAD_EXP)))
        else $error("REJ reply does not match frame status");

    a_good_new_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && state_reg == ST_DATA && s_tdata == FLAG_BYTE && good && expected)
            |=> (expected_seq_reg != $past(expected_seq_reg)))
        else $error("expected sequence bit did not advance");

    a_escape_returns_to_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && state_reg == ST_ESC) |=> (state_reg == ST_DATA))
        else $error("escape state did not return to payload");

endmodule : stuffed_frame_receiver
`default_nettype wire

>>> verif/stuffed_frame_receiver_tb.sv
// ============================================================================
// stuffed_frame_receiver_tb: self-checking bench for the frame receiver
// Feeds line bytes (directed frames, then random good, broken and noise
// frames) through the input stream. A scoreboard tracks the parser, the
// sequence bits and the one-byte payload delay to predict one result per
// byte, and checks every result transfer in order. The address register is
// rewritten between phases while the block is idle.
// ============================================================================
module stuffed_frame_receiver_tb
    import sfr_pkg::*;
();

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;
    localparam logic [PADDR_W-1:0] ADDRESS_BYTE_PADDR = {REG_ADDRESS, 2'b00};

    // Parser position, kept by the scoreboard
    typedef enum logic [2:0] {
        HUNT, AFTER_FLAG, GOT_ADDR, GOT_CTRL, IN_DATA, IN_ESC
    } parse_state_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the receiver and checks results in order
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]   address;
        parse_state_t parse;
        logic         frame_seq;
        logic         expected_seq;
        logic [7:0]   held_byte;
        logic         held_valid;
        logic [7:0]   running_xor;
        result_t      pending_results[$];
        int           error_count;

        function new();
            address      = ADDR_RESET;
            parse        = HUNT;
            frame_seq    = 1'b0;
            expected_seq = 1'b0;
            held_byte    = '0;
            held_valid   = 1'b0;
            running_xor  = '0;
            error_count  = 0;
        endfunction

        function void report(string msg);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        // Release the held payload byte and hold the new one
        function void take_payload(logic [7:0] b, inout result_t r);
            if (held_valid) begin
                r.data_valid = 1'b1;
                r.data_byte  = held_byte;
            end
            held_byte   = b;
            held_valid  = 1'b1;
            running_xor = running_xor ^ b;
        endfunction

        function void clear_payload();
            held_byte   = '0;
            held_valid  = 1'b0;
            running_xor = '0;
        endfunction

        // Predict the result of one accepted line byte
        function void note_line_byte(logic [7:0] b);
            result_t r;
            logic    good;
            logic    on_time;
            r = '0;
            case (parse)
                AFTER_FLAG: begin
                    if (b == address)
                        parse = GOT_ADDR;
                    else if (b != FLAG_BYTE)
                        parse = HUNT;
                end
                GOT_ADDR: begin
                    if (b == CTRL_SEQ0) begin
                        frame_seq = 1'b0;
                        parse = GOT_CTRL;
                    end else if (b == CTRL_SEQ1) begin
                        frame_seq = 1'b1;
                        parse = GOT_CTRL;
                    end else if (b == FLAG_BYTE) begin
                        parse = AFTER_FLAG;
                    end else begin
                        parse = HUNT;
                    end
                end
                GOT_CTRL: begin
                    if (b == (address ^ (frame_seq ? CTRL_SEQ1 : CTRL_SEQ0))) begin
                        parse = IN_DATA;
                        clear_payload();
                    end else if (b == FLAG_BYTE) begin
                        parse = AFTER_FLAG;
                    end else begin
                        parse = HUNT;
                    end
                end
                IN_DATA: begin
                    if (b == ESC_BYTE) begin
                        parse = IN_ESC;
                    end else if (b == FLAG_BYTE) begin
                        // closing flag: an empty frame never passes the check
                        good    = held_valid && (running_xor == 8'h00);
                        on_time = (frame_seq == expected_seq);
                        if (good && on_time) begin
                            r.frame_status = STAT_GOOD_NEW;
                            expected_seq   = ~expected_seq;
                        end else if (good) begin
                            r.frame_status = STAT_GOOD_DUP;
                        end else if (on_time) begin
                            r.frame_status    = STAT_BAD_EXP;
                            r.reply_is_reject = 1'b1;
                        end else begin
                            r.frame_status = STAT_BAD_DUP;
                        end
                        r.frame_done = 1'b1;
                        r.reply_seq  = expected_seq;
                        clear_payload();
                        parse = HUNT;
                    end else begin
                        take_payload(b, r);
                    end
                end
                IN_ESC: begin
                    // a bad escape drops both bytes, even a following flag
                    if (b == ESC_FLAG)
                        take_payload(FLAG_BYTE, r);
                    else if (b == ESC_ESC)
                        take_payload(ESC_BYTE, r);
                    parse = IN_DATA;
                end
                default: begin
                    parse = (b == FLAG_BYTE) ? AFTER_FLAG : HUNT;
                end
            endcase
            pending_results.push_back(r);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast, logic tuser);
            result_t want;
            logic    bad;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result tdata=%h tlast=%b tuser=%b",
                                 tdata, tlast, tuser));
                return;
            end
            want = pending_results.pop_front();
            bad = (tuser !== want.data_valid) ||
                  (tdata[7:0] !== want.data_byte) ||
                  (tdata[9:8] !== want.frame_status) ||
                  (tdata[10] !== want.reply_is_reject) ||
                  (tdata[11] !== want.reply_seq) ||
                  (tlast !== want.frame_done) ||
                  (tdata[M_TDATA_W-1:12] !== '0);
            if (bad)
                report($sformatf({"result mismatch: expected dv=%b byte=%h done=%b st=%0d ",
                                  "rej=%b seq=%b, got dv=%b byte=%h done=%b st=%0d rej=%b ",
                                  "seq=%b pad=%h"},
                                 want.data_valid, want.data_byte, want.frame_done,
                                 want.frame_status, want.reply_is_reject, want.reply_seq,
                                 tuser, tdata[7:0], tlast, tdata[9:8], tdata[10],
                                 tdata[11], tdata[M_TDATA_W-1:12]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [7:0] data_byte, [9:8] frame_status,
                                     // [10] reply_is_reject, [11] reply_seq
    logic                 m_tlast;   // frame_done
    logic                 m_tuser;   // [0] data_valid
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    frame_scoreboard sb;
    logic [7:0]      line_q[$];
    int              bytes_sent   = 0;
    int              quiet_cycles = 0;
    int              tx_free_left = 0;
    int              rx_free_left = 0;
    int              rx_stall_left = 0;
    bit              hold_off_req = 1'b0;
    bit              holding      = 1'b0;

    stuffed_frame_receiver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Idle pattern: mostly short gaps, a few long ones, some gap-free runs
    // ------------------------------------------------------------------------
    function automatic int pick_idle(inout int free_left);
        int r;
        if (free_left > 0) begin
            free_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(8, 30);
        free_left = $urandom_range(20, 80);
        return 0;
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                holding = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                holding = 1'b0;
                m_tready <= 1'b1;
            end else if (rx_stall_left > 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_tready <= 1'b1;
                rx_stall_left = pick_idle(rx_free_left);
            end
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_line_byte(input logic [7:0] b);
        int gap;
        gap = holding ? 0 : pick_idle(tx_free_left);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_line_byte(b);
        bytes_sent++;
    endtask

    task automatic idle_line();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [7:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDRESS_BYTE_PADDR;
        pwdata  <= {24'h0, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (wr)
            sb.address = v;
        else if (prdata !== {24'h0, v})
            sb.report($sformatf("address readback: expected %h, got %h", v, prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------------
    function automatic void push_stuffed(logic [7:0] v);
        if (v == FLAG_BYTE) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(ESC_FLAG);
        end else if (v == ESC_BYTE) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(ESC_ESC);
        end else begin
            line_q.push_back(v);
        end
    endfunction

    // Escape followed by anything but the two legal codes
    function automatic void push_bad_escape();
        logic [7:0] v;
        v = ($urandom_range(0, 3) == 0) ? FLAG_BYTE : 8'($urandom);
        if (v == ESC_FLAG || v == ESC_ESC)
            v = FLAG_BYTE;
        line_q.push_back(ESC_BYTE);
        line_q.push_back(v);
    endfunction

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return FLAG_BYTE;
        if (r == 1)
            return ESC_BYTE;
        return 8'($urandom);
    endfunction

    // Build one frame (good, bad check, empty, bad escape, broken header)
    // or a burst of noise, then send it
    task automatic send_frame();
        logic [7:0] hdr_b[3];
        logic [7:0] chk;
        logic [7:0] v;
        logic       seq;
        int         kind;
        int         len;
        int         bad_at;
        int         cut_at;
        line_q.delete();
        kind = $urandom_range(0, 99);
        seq = ($urandom_range(0, 3) != 0) ? sb.expected_seq : 1'($urandom_range(0, 1));
        hdr_b[0] = sb.address;
        hdr_b[1] = seq ? CTRL_SEQ1 : CTRL_SEQ0;
        hdr_b[2] = hdr_b[0] ^ hdr_b[1];
        if (kind >= 92) begin
            repeat ($urandom_range(1, 6))
                line_q.push_back(($urandom_range(0, 4) == 0) ? FLAG_BYTE : 8'($urandom));
        end else begin
            line_q.push_back(FLAG_BYTE);
            if ($urandom_range(0, 4) == 0)
                line_q.push_back(FLAG_BYTE);
            if (kind >= 83) begin
                // break the header at one byte: resync on a flag or a wrong byte
                cut_at = $urandom_range(0, 2);
                for (int i = 0; i < cut_at; i++)
                    line_q.push_back(hdr_b[i]);
                if ($urandom_range(0, 1) == 0) begin
                    line_q.push_back(FLAG_BYTE);
                    foreach (hdr_b[i])
                        line_q.push_back(hdr_b[i]);
                end else begin
                    v = 8'($urandom);
                    if (v == hdr_b[cut_at])
                        v = v ^ 8'h01;
                    line_q.push_back(v);
                end
            end else begin
                foreach (hdr_b[i])
                    line_q.push_back(hdr_b[i]);
            end
            if (kind < 70 || kind >= 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
                bad_at = (kind >= 75 && kind < 83) ? $urandom_range(0, len) : -1;
                chk = 8'h00;
                for (int i = 0; i < len; i++) begin
                    if (i == bad_at)
                        push_bad_escape();
                    v = pick_payload();
                    chk = chk ^ v;
                    push_stuffed(v);
                end
                if (bad_at == len)
                    push_bad_escape();
                if (kind >= 60 && kind < 70)
                    chk = chk ^ 8'($urandom_range(1, 255));
                push_stuffed(chk);
            end
            line_q.push_back(FLAG_BYTE);
        end
        foreach (line_q[i])
            send_line_byte(line_q[i]);
    endtask

    task automatic run_random(input int count, input bit hold_off);
        int target;
        target = bytes_sent + count;
        if (hold_off)
            hold_off_req = 1'b1;
        while (bytes_sent < target)
            send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] directed[$];
        logic [7:0] addr_plan[$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        apb_access(1'b0, ADDR_RESET);

        // good new frame with both escapes, sequence 0
        directed = '{8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'hFF,
                     8'hFC, 8'h7E,
        // empty frame, sequence 1: check error with reject
                     8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
        // escape then flag is dropped; repeated sequence 0 is a good duplicate
                     8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h7E, 8'h00, 8'h7E};
        foreach (directed[i])
            send_line_byte(directed[i]);
        run_random(80, 1'b0);

        // address settings: extremes, flag value, control codes, random, reset value
        addr_plan = '{8'hFF, 8'h00, 8'h7E, 8'h40, 8'($urandom), ADDR_RESET};
        foreach (addr_plan[i]) begin
            idle_line();
            wait_drained();
            apb_access(1'b1, addr_plan[i]);
            apb_access(1'b0, addr_plan[i]);
            run_random(92, i == 0 || i == 3);
        end

        idle_line();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
